[rtl/core/efs_pkg.sv]
// shared types, codes and constants of the elevator floor scheduler
package efs_pkg;

    localparam int FLOOR_W             = 4;
    localparam int FIELD_MAX           = 15;
    localparam int DEFAULT_FLOOR_COUNT = 16;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_PLAN   = 2'd1,
        OP_STEP   = 2'd2,
        OP_ESCAPE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_UP   = 2'd1,
        DIR_DOWN = 2'd2
    } dir_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_NO_REQ   = 2'd1,
        STAT_NO_FLOOR = 2'd2,
        STAT_RANGE    = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    // command broadcast to every cell
    typedef struct packed {
        logic               set;
        logic               clr;
        logic [FLOOR_W-1:0] floor;
    } cell_cmd_t;

    // scan record handed from cell to cell
    typedef struct packed {
        logic [1:0]         count;
        logic [FLOOR_W-1:0] single;
        logic               found;
        logic [FLOOR_W-1:0] best;
        logic [FLOOR_W-1:0] gap;
        logic               above;
        logic               below;
    } scan_t;

endpackage

[rtl/core/efs_cell.sv]
// one floor cell: request bit and one stage of the nearest-floor scan
module efs_cell
    import efs_pkg::*;
#(
    parameter int CELL_INDEX = 0
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  cell_cmd_t          cmd,
    input  logic [FLOOR_W-1:0] car_floor,
    input  scan_t              scan_in,
    output scan_t              scan_out,
    output logic               hit
);

    localparam logic [FLOOR_W-1:0] IDX = FLOOR_W'(CELL_INDEX);

    logic               req_reg;
    logic               req_next;
    scan_t              scan_reg;
    scan_t              scan_next;
    logic [FLOOR_W-1:0] d;

    assign hit = req_reg && (cmd.floor == IDX);

    always_comb begin
        req_next = req_reg;
        if (cmd.set && (cmd.floor == IDX)) begin
            req_next = 1'b1;
        end else if (cmd.clr && (cmd.floor == IDX)) begin
            req_next = 1'b0;
        end
    end

    always_comb begin
        d         = (IDX > car_floor) ? (IDX - car_floor) : (car_floor - IDX);
        scan_next = scan_in;
        if (req_reg) begin
            scan_next.count  = (scan_in.count == 2'd2) ? 2'd2 : scan_in.count + 2'd1;
            scan_next.single = IDX;
            if (IDX > car_floor) begin
                scan_next.above = 1'b1;
            end
            if (IDX < car_floor) begin
                scan_next.below = 1'b1;
            end
            if ((IDX != car_floor) && (!scan_in.found || (d < scan_in.gap))) begin
                scan_next.best  = IDX;
                scan_next.gap   = d;
                scan_next.found = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_reg <= 1'b0;
        end else begin
            req_reg <= req_next;
        end
    end

    always_ff @(posedge aclk) begin
        scan_reg <= scan_next;
    end

    assign scan_out = scan_reg;

endmodule

[rtl/core/elevator_floor_scheduler_unit.sv]
// elevator floor scheduler top level: sequencer, car state and chain of floor cells
// an item's scan walks the cell chain, and the item is held in ST_DONE until the output register
// can take the result; only then is the next item accepted (s_ready is high in ST_IDLE only)
// a finished result waits in the output register while the next item is scanned
// reset (aresetn low, synchronous): car at floor 0, no requests, direction none, flags clear,
// top floor register 15; cfg_ready is always high
module elevator_floor_scheduler_unit
    import efs_pkg::*;
#(
    parameter int FLOOR_COUNT = DEFAULT_FLOOR_COUNT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [FLOOR_W-1:0] cfg_top_floor,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_op,
    input  logic [FLOOR_W-1:0] s_request_floor,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [FLOOR_W-1:0] m_floor_now,
    output logic [FLOOR_W-1:0] m_target_floor,
    output logic [1:0]         m_direction,
    output logic               m_running,
    output logic               m_stopped_here,
    output logic               m_switch_advised,
    output logic               m_requests_pending,
    output logic [1:0]         m_status
);

    localparam int LAST_INT  = (FLOOR_COUNT - 1 < FIELD_MAX) ? FLOOR_COUNT - 1 : FIELD_MAX;
    localparam int NUM_CELLS = LAST_INT + 1;
    localparam int CNT_W     = $clog2(NUM_CELLS);
    localparam logic [FLOOR_W-1:0] LAST_FLOOR = FLOOR_W'(LAST_INT);
    localparam logic [CNT_W-1:0]   CNT_END    = CNT_W'(NUM_CELLS - 1);

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    op_t                op_reg, op_next;
    logic [FLOOR_W-1:0] top_floor_reg;
    logic [FLOOR_W-1:0] car_floor_reg, car_floor_next;
    logic [FLOOR_W-1:0] target_reg, target_next;
    dir_t               dir_reg, dir_next;
    logic               run_reg, run_next;
    logic               stopped_reg, stopped_next;
    status_t            status_reg, status_next;
    status_t            final_status;
    logic               m_valid_reg;
    logic [FLOOR_W-1:0] m_floor_now_reg, m_target_floor_reg;
    logic [1:0]         m_direction_reg, m_status_reg;
    logic               m_running_reg, m_stopped_here_reg;
    logic               m_switch_advised_reg, m_requests_pending_reg;

    logic               s_fire;
    logic               out_load;
    logic [FLOOR_W-1:0] highest_usable;
    logic [FLOOR_W-1:0] pick;
    logic               switch_adv;
    cell_cmd_t          cmd;
    scan_t              scan_chain [NUM_CELLS];
    scan_t              scan_last;
    logic [NUM_CELLS-1:0] hit_vec;

    assign cfg_ready      = 1'b1;
    assign s_fire         = s_valid && s_ready;
    assign highest_usable = (top_floor_reg < LAST_FLOOR) ? top_floor_reg : LAST_FLOOR;
    assign scan_last      = scan_chain[NUM_CELLS-1];

    // floor cell chain
    for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
        scan_t scan_in;
        if (i == 0) begin : g_head
            assign scan_in = '0;
        end else begin : g_link
            assign scan_in = scan_chain[i-1];
        end
        efs_cell #(
            .CELL_INDEX(i)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cmd      (cmd),
            .car_floor(car_floor_reg),
            .scan_in  (scan_in),
            .scan_out (scan_chain[i]),
            .hit      (hit_vec[i])
        );
    end

    // next state
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    state_next = ST_SCAN;
                    cnt_next   = '0;
                end
            end
            ST_SCAN: begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_END) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // fsm outputs
    always_comb begin
        s_ready  = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            ST_IDLE: s_ready  = 1'b1;
            ST_DONE: out_load = !m_valid_reg || m_ready;
            default: begin
                s_ready  = 1'b0;
                out_load = 1'b0;
            end
        endcase
    end

    // item entry: add, step and escape act at accept
    always_comb begin
        cmd            = '0;
        op_next        = op_reg;
        car_floor_next = car_floor_reg;
        stopped_next   = stopped_reg;
        status_next    = status_reg;
        if (s_fire) begin
            op_next     = op_t'(s_op);
            status_next = STAT_OK;
            case (op_t'(s_op))
                OP_ADD: begin
                    if ((s_request_floor > top_floor_reg) || (s_request_floor > LAST_FLOOR)) begin
                        status_next = STAT_RANGE;
                    end else begin
                        cmd.set   = 1'b1;
                        cmd.floor = s_request_floor;
                    end
                end
                OP_STEP: begin
                    if (run_reg) begin
                        if ((dir_reg == DIR_UP) && (car_floor_reg < highest_usable)) begin
                            car_floor_next = car_floor_reg + FLOOR_W'(1);
                            cmd.clr        = 1'b1;
                        end else if ((dir_reg == DIR_DOWN) && (car_floor_reg != '0)) begin
                            car_floor_next = car_floor_reg - FLOOR_W'(1);
                            cmd.clr        = 1'b1;
                        end
                        if (cmd.clr) begin
                            cmd.floor    = car_floor_next;
                            stopped_next = |hit_vec;
                        end
                    end
                end
                OP_ESCAPE: begin
                    if (car_floor_reg < highest_usable) begin
                        car_floor_next = car_floor_reg + FLOOR_W'(1);
                    end else if (car_floor_reg != '0) begin
                        car_floor_next = car_floor_reg - FLOOR_W'(1);
                    end
                end
                default: begin
                    cmd = '0;
                end
            endcase
        end
    end

    // plan and result assembly from the finished scan
    always_comb begin
        target_next  = target_reg;
        dir_next     = dir_reg;
        run_next     = run_reg;
        final_status = status_reg;
        pick         = (scan_last.count == 2'd1) ? scan_last.single : scan_last.best;
        if (op_reg == OP_PLAN) begin
            if (scan_last.count == 2'd0) begin
                run_next     = 1'b0;
                final_status = STAT_NO_REQ;
            end else begin
                target_next = pick;
                if (pick > top_floor_reg) begin
                    run_next     = 1'b0;
                    final_status = STAT_NO_FLOOR;
                end else begin
                    if (car_floor_reg < pick) begin
                        dir_next = DIR_UP;
                    end else if (car_floor_reg > pick) begin
                        dir_next = DIR_DOWN;
                    end
                    run_next     = 1'b1;
                    final_status = STAT_OK;
                end
            end
        end
        case (dir_next)
            DIR_UP:   switch_adv = !scan_last.above;
            DIR_DOWN: switch_adv = !scan_last.below;
            default:  switch_adv = 1'b1;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            op_reg        <= OP_ADD;
            top_floor_reg <= FLOOR_W'(FIELD_MAX);
            car_floor_reg <= '0;
            target_reg    <= '0;
            dir_reg       <= DIR_NONE;
            run_reg       <= 1'b0;
            stopped_reg   <= 1'b0;
            status_reg    <= STAT_OK;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            op_reg        <= op_next;
            car_floor_reg <= car_floor_next;
            stopped_reg   <= stopped_next;
            status_reg    <= status_next;
            if (cfg_valid && cfg_ready) begin
                top_floor_reg <= cfg_top_floor;
            end
            if (out_load) begin
                target_reg  <= target_next;
                dir_reg     <= dir_next;
                run_reg     <= run_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_floor_now_reg        <= car_floor_reg;
            m_target_floor_reg     <= target_next;
            m_direction_reg        <= dir_next;
            m_running_reg          <= run_next;
            m_stopped_here_reg     <= stopped_reg;
            m_switch_advised_reg   <= switch_adv;
            m_requests_pending_reg <= (scan_last.count != 2'd0);
            m_status_reg           <= final_status;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_floor_now        = m_floor_now_reg;
    assign m_target_floor     = m_target_floor_reg;
    assign m_direction        = m_direction_reg;
    assign m_running          = m_running_reg;
    assign m_stopped_here     = m_stopped_here_reg;
    assign m_switch_advised   = m_switch_advised_reg;
    assign m_requests_pending = m_requests_pending_reg;
    assign m_status           = m_status_reg;

endmodule
